FILE: rtl/biquad_pkg.sv
// biquad_pkg: types, constants and saturating fixed-point helpers for the biquad filter.
// No dependencies. Used by the interfaces, the datapath and the top level.
package biquad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WIDE_W   = 32;
  localparam int COEF_W   = 16;
  localparam int CFG_IDX_W = 3;

  // extra left shift that turns a Q15 fractional product into a Q14-coefficient product
  localparam int COEF_SHIFT = 15 - 14;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = 32'sh8000_0000;
  localparam logic signed [WIDE_W-1:0] ROUND_HALF = 32'sh0000_8000;

  localparam logic signed [COEF_W-1:0] B0_RESET = 16'sd16384;
  localparam logic signed [COEF_W-1:0] B1_RESET = 16'sd0;
  localparam logic signed [COEF_W-1:0] B2_RESET = 16'sd0;
  localparam logic signed [COEF_W-1:0] A1_RESET = 16'sd0;
  localparam logic signed [COEF_W-1:0] A2_RESET = 16'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0 = 3'd0,
    CFG_B1 = 3'd1,
    CFG_B2 = 3'd2,
    CFG_A1 = 3'd3,
    CFG_A2 = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

  // double with saturation to 32 bits
  function automatic logic signed [WIDE_W-1:0] sat_dbl(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] r;
    if (v[WIDE_W-1] != v[WIDE_W-2]) begin
      r = v[WIDE_W-1] ? WIDE_MIN : WIDE_MAX;
    end else begin
      r = {v[WIDE_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // 32-bit add with saturation
  function automatic logic signed [WIDE_W-1:0] sat_add(input logic signed [WIDE_W-1:0] a,
                                                      input logic signed [WIDE_W-1:0] b);
    logic signed [WIDE_W:0] s;
    logic signed [WIDE_W-1:0] r;
    s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
    if (s[WIDE_W] != s[WIDE_W-1]) begin
      r = s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
    end else begin
      r = s[WIDE_W-1:0];
    end
    return r;
  endfunction

  // Q31 to Q15 with round-half-up and saturation
  function automatic logic signed [SAMPLE_W-1:0] round_q15(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] r;
    r = sat_add(v, ROUND_HALF);
    return r[WIDE_W-1:WIDE_W-SAMPLE_W];
  endfunction

  // saturating fractional multiply, then the coefficient format shift
  function automatic logic signed [WIDE_W-1:0] frac_term(input logic signed [SAMPLE_W-1:0] a,
                                                        input logic signed [COEF_W-1:0] b);
    logic signed [WIDE_W-1:0] p;
    p = WIDE_W'(a) * WIDE_W'(b);
    p = sat_dbl(p);
    for (int i = 0; i < COEF_SHIFT; i++) begin
      p = sat_dbl(p);
    end
    return p;
  endfunction

endpackage

FILE: rtl/biquad_in_if.sv
// biquad_in_if: valid/ready channel carrying one Q15 input sample.
// Depends on biquad_pkg for the sample width.
interface biquad_in_if
  import biquad_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

FILE: rtl/biquad_out_if.sv
// biquad_out_if: valid/ready channel carrying one filter result (Q31 and rounded Q15).
// Depends on biquad_pkg for the field widths.
interface biquad_out_if
  import biquad_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [WIDE_W-1:0]   sample_out_wide;
  logic signed [SAMPLE_W-1:0] sample_out_round;

  modport source (output valid, output sample_out_wide, output sample_out_round, input ready);
  modport sink   (input valid, input sample_out_wide, input sample_out_round, output ready);
endinterface

FILE: rtl/biquad_dp.sv
// biquad_dp: combinational direct form I datapath, five saturating terms and the add chain.
// Depends on biquad_pkg for the coefficient set and the saturating helpers.
module biquad_dp
  import biquad_pkg::*;
(
  input  coef_set_t                  coefs,
  input  logic signed [SAMPLE_W-1:0] x,
  input  logic signed [SAMPLE_W-1:0] x1,
  input  logic signed [SAMPLE_W-1:0] x2,
  input  logic signed [WIDE_W-1:0]   y1,
  input  logic signed [WIDE_W-1:0]   y2,
  output logic signed [WIDE_W-1:0]   acc,
  output logic signed [SAMPLE_W-1:0] acc_round
);

  logic signed [WIDE_W-1:0] t_a2, t_a1, t_b2, t_b1, t_b0;
  logic signed [WIDE_W-1:0] s1, s2, s3;

  // fed-back outputs go through Q15 first
  assign t_a2 = frac_term(round_q15(y2), coefs.a2);
  assign t_a1 = frac_term(round_q15(y1), coefs.a1);
  assign t_b2 = frac_term(x2, coefs.b2);
  assign t_b1 = frac_term(x1, coefs.b1);
  assign t_b0 = frac_term(x, coefs.b0);

  // fixed summation order, saturating at every step
  assign s1  = sat_add(t_a2, t_a1);
  assign s2  = sat_add(s1, t_b2);
  assign s3  = sat_add(s2, t_b1);
  assign acc = sat_add(s3, t_b0);

  assign acc_round = round_q15(acc);

endmodule

FILE: rtl/biquad_iir_q14_saturating.sv
// biquad_iir_q14_saturating: top level of the Q14-coefficient direct form I biquad.
// Depends on biquad_pkg, biquad_in_if, biquad_out_if and biquad_dp.
//
// Second-order IIR section, direct form I. Each request on in_ch carries one Q15 sample;
// each request on out_ch carries the saturated Q31 output and its Q15 rounded copy, one
// result per sample, in order. Throughput is one sample per clock while out_ch keeps ready
// high: a sample is held in the input register, then the datapath (five 16x16 multiplies
// and a chain of four saturating 32-bit adds) writes the result register and the history
// in the same edge, once the result register is free, and the result register offers it on
// out_ch. With out_ch stalled the block holds two samples and then drops in_ch.ready. The
// loop through prev_out_1, the Q15 rounding, a multiply and the add chain is the critical
// path. Coefficients are written through cfg_we/cfg_idx/cfg_wdata; the user must write
// them only while the filter is idle, the block itself does not enforce this. Indexes
// past coef_a2 are ignored. Reset clears the history and loads b0 = 1.0 (16384 in Q14),
// all other coefficients zero, i.e. a pass-through at unity gain.
module biquad_iir_q14_saturating
  import biquad_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  biquad_in_if.sink            in_ch,
  biquad_out_if.source         out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COEF_W-1:0]    cfg_wdata
);

  // coefficient registers
  coef_set_t coefs_r, coefs_nxt;

  // input stage
  logic                       in_v_r;
  logic signed [SAMPLE_W-1:0] in_x_r;

  // filter history
  logic signed [SAMPLE_W-1:0] prev_in_1_r, prev_in_2_r;
  logic signed [WIDE_W-1:0]   prev_out_1_r, prev_out_2_r;

  // result stage
  logic                       out_v_r;
  logic signed [WIDE_W-1:0]   out_wide_r;
  logic signed [SAMPLE_W-1:0] out_round_r;

  logic                       in_take;
  logic                       out_free;
  logic                       compute;
  logic signed [WIDE_W-1:0]   acc;
  logic signed [SAMPLE_W-1:0] acc_round;

  // result register frees when empty or being drained this cycle
  assign out_free = !out_v_r || out_ch.ready;
  // input stage moves into the result stage
  assign compute  = in_v_r && out_free;
  // input stage can take a sample when empty or moving on
  assign in_ch.ready = !in_v_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign out_ch.valid            = out_v_r;
  assign out_ch.sample_out_wide  = out_wide_r;
  assign out_ch.sample_out_round = out_round_r;

  // coefficient write decode
  always_comb begin
    coefs_nxt = coefs_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_B0:  coefs_nxt.b0 = cfg_wdata;
        CFG_B1:  coefs_nxt.b1 = cfg_wdata;
        CFG_B2:  coefs_nxt.b2 = cfg_wdata;
        CFG_A1:  coefs_nxt.a1 = cfg_wdata;
        CFG_A2:  coefs_nxt.a2 = cfg_wdata;
        default: ;  // no register at this index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r.b0 <= B0_RESET;
      coefs_r.b1 <= B1_RESET;
      coefs_r.b2 <= B2_RESET;
      coefs_r.a1 <= A1_RESET;
      coefs_r.a2 <= A2_RESET;
    end else begin
      coefs_r <= coefs_nxt;
    end
  end

  biquad_dp u_dp (
    .coefs     (coefs_r),
    .x         (in_x_r),
    .x1        (prev_in_1_r),
    .x2        (prev_in_2_r),
    .y1        (prev_out_1_r),
    .y2        (prev_out_2_r),
    .acc       (acc),
    .acc_round (acc_round)
  );

  // handshake state and filter history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      prev_in_1_r  <= '0;
      prev_in_2_r  <= '0;
      prev_out_1_r <= '0;
      prev_out_2_r <= '0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (out_free) begin
        out_v_r <= in_v_r;
      end
      // history advances exactly once per computed sample
      if (compute) begin
        prev_in_2_r  <= prev_in_1_r;
        prev_in_1_r  <= in_x_r;
        prev_out_2_r <= prev_out_1_r;
        prev_out_1_r <= acc;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_x_r <= in_ch.sample_in;
    end
    if (compute) begin
      out_wide_r  <= acc;
      out_round_r <= acc_round;
    end
  end

endmodule

FILE: tb/biquad_out_check.sv
// biquad_out_check: watches the sample, result and coefficient ports of the biquad,
// predicts every result bit for bit and compares it field by field.
// Depends on biquad_pkg, biquad_in_if and biquad_out_if.
module biquad_out_check
  import biquad_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  biquad_in_if                 in_ch,
  biquad_out_if                out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COEF_W-1:0]    cfg_wdata,
  output int                   fail_count,
  output int                   owed_results
);

  typedef struct packed {
    logic signed [WIDE_W-1:0]   wide;
    logic signed [SAMPLE_W-1:0] rounded;
  } filter_out_t;

  filter_out_t pending_outputs[$];

  // shadow copy of the coefficients and the filter history
  coef_set_t                  coefs;
  logic signed [SAMPLE_W-1:0] x_d1, x_d2;
  logic signed [WIDE_W-1:0]   y_d1, y_d2;
  int                         fails = 0;

  assign fail_count = fails;

  function automatic logic signed [WIDE_W-1:0] clip_wide(input longint v);
    logic signed [WIDE_W-1:0] r;
    if (v > longint'(WIDE_MAX)) begin
      r = WIDE_MAX;
    end else if (v < longint'(WIDE_MIN)) begin
      r = WIDE_MIN;
    end else begin
      r = v[WIDE_W-1:0];
    end
    return r;
  endfunction

  // round half up to q15, saturating at the top
  function automatic logic signed [SAMPLE_W-1:0] q15_of(input logic signed [WIDE_W-1:0] y);
    logic signed [WIDE_W-1:0] t;
    t = clip_wide(longint'(y) + 64'sd32768);
    return t[WIDE_W-1:WIDE_W-SAMPLE_W];
  endfunction

  // fractional product, doubled with saturation, then the q14 shift
  function automatic logic signed [WIDE_W-1:0] weighted(input logic signed [SAMPLE_W-1:0] s,
                                                       input logic signed [COEF_W-1:0] c);
    longint p;
    p = longint'(clip_wide(longint'(s) * longint'(c) * 2));
    for (int i = 0; i < COEF_SHIFT; i++) begin
      p = longint'(clip_wide(p * 2));
    end
    return p[WIDE_W-1:0];
  endfunction

  // sum order: a2, a1, b2, b1, b0, each partial sum saturated
  function automatic logic signed [WIDE_W-1:0] filter_response(
      input logic signed [SAMPLE_W-1:0] x);
    logic signed [WIDE_W-1:0] acc;
    acc = weighted(q15_of(y_d2), coefs.a2);
    acc = clip_wide(longint'(acc) + longint'(weighted(q15_of(y_d1), coefs.a1)));
    acc = clip_wide(longint'(acc) + longint'(weighted(x_d2, coefs.b2)));
    acc = clip_wide(longint'(acc) + longint'(weighted(x_d1, coefs.b1)));
    acc = clip_wide(longint'(acc) + longint'(weighted(x, coefs.b0)));
    return acc;
  endfunction

  always @(posedge clk) begin : track
    filter_out_t want;
    logic signed [WIDE_W-1:0] y;
    if (!rst_n) begin
      coefs = '{b0: B0_RESET, b1: B1_RESET, b2: B2_RESET, a1: A1_RESET, a2: A2_RESET};
      x_d1 = '0;
      x_d2 = '0;
      y_d1 = '0;
      y_d2 = '0;
      pending_outputs.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_outputs.size() == 0) begin
          $error("result with no sample waiting: sample_out_wide %0d sample_out_round %0d",
                 out_ch.sample_out_wide, out_ch.sample_out_round);
          fails++;
        end else begin
          want = pending_outputs.pop_front();
          if (out_ch.sample_out_wide !== want.wide) begin
            $error("sample_out_wide: expected %0d, got %0d", want.wide,
                   out_ch.sample_out_wide);
            fails++;
          end
          if (out_ch.sample_out_round !== want.rounded) begin
            $error("sample_out_round: expected %0d, got %0d", want.rounded,
                   out_ch.sample_out_round);
            fails++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        y = filter_response(in_ch.sample_in);
        want.wide    = y;
        want.rounded = q15_of(y);
        pending_outputs.push_back(want);
        x_d2 = x_d1;
        x_d1 = in_ch.sample_in;
        y_d2 = y_d1;
        y_d1 = y;
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_B0:  coefs.b0 = cfg_wdata;
          CFG_B1:  coefs.b1 = cfg_wdata;
          CFG_B2:  coefs.b2 = cfg_wdata;
          CFG_A1:  coefs.a1 = cfg_wdata;
          CFG_A2:  coefs.a2 = cfg_wdata;
          default: ;
        endcase
      end
    end
    owed_results <= pending_outputs.size();
  end

endmodule

FILE: tb/tb_top.sv
// tb_top: stimulus and verdict for biquad_iir_q14_saturating.
// Depends on biquad_pkg, biquad_in_if, biquad_out_if, the block itself and
// biquad_out_check, which predicts and compares every result.
module tb_top
  import biquad_pkg::*;
();

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 70;
  localparam int HOLD_PHASE     = 2;
  localparam int PAUSE_PHASE    = 5;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES   = 4;
  localparam int MAX_BURST      = 18;
  localparam int CYCLE_LIMIT    = 200000;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [COEF_W-1:0]   C_MAX = 16'sh7FFF;
  localparam logic signed [COEF_W-1:0]   C_MIN = 16'sh8000;
  localparam logic signed [COEF_W-1:0]   C_ONE = 16'sh4000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COEF_W-1:0]    cfg_wdata;
  int                   fail_count;
  int                   owed_results;
  int                   cycle_count = 0;

  // knobs shared between the sending and the receiving side
  bit                   calm;          // last part of the run: no idling at all
  int                   rx_hold_ask;   // bumped to ask the receiver for one long hold-off
  int                   gap_pct;       // chance of a sender gap before a request

  biquad_in_if  in_ch ();
  biquad_out_if out_ch ();

  biquad_iir_q14_saturating u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  biquad_out_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .owed_results (owed_results)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[biquad_iir_q14_saturating] ERROR");
      $finish;
    end
  end

  // one sample request, with an optional idle burst in front of it;
  // returns at the edge where the request is taken
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    if (!calm && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending and wait until every result owed has come back, then a drain
  // margin for the two-stage pipe; the first edge lets the checker
  // count the request taken at the current edge
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write per edge; write enable stays high across the burst
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // all five coefficients, then junk into the unused indexes, which must be ignored
  task automatic load_coefs(input coef_set_t c);
    put_reg(CFG_B0, c.b0);
    put_reg(CFG_B1, c.b1);
    put_reg(CFG_B2, c.b2);
    put_reg(CFG_A1, c.a1);
    put_reg(CFG_A2, c.a2);
    for (int k = int'(CFG_A2) + 1; k < (1 << CFG_IDX_W); k++) begin
      put_reg(CFG_IDX_W'(k), COEF_W'($urandom()));
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [COEF_W-1:0] corner_coef();
    logic signed [COEF_W-1:0] v;
    case ($urandom_range(0, 4))
      0:       v = C_MIN;
      1:       v = C_MAX;
      2:       v = '0;
      3:       v = -16'sd1;
      default: v = C_ONE;
    endcase
    return v;
  endfunction

  // mix of fully random sets (mostly saturating), corner sets and
  // roughly stable sections whose output actually rings
  function automatic coef_set_t pick_coefs();
    coef_set_t c;
    int        mag;
    int        lim;
    case ($urandom_range(0, 3))
      0: begin
        c.b0 = COEF_W'($urandom());
        c.b1 = COEF_W'($urandom());
        c.b2 = COEF_W'($urandom());
        c.a1 = COEF_W'($urandom());
        c.a2 = COEF_W'($urandom());
      end
      1: begin
        c.b0 = corner_coef();
        c.b1 = corner_coef();
        c.b2 = corner_coef();
        c.a1 = corner_coef();
        c.a2 = corner_coef();
      end
      default: begin
        c.b0 = COEF_W'(int'($urandom_range(0, 8192)) - 4096);
        c.b1 = COEF_W'(int'($urandom_range(0, 8192)) - 4096);
        c.b2 = COEF_W'(int'($urandom_range(0, 8192)) - 4096);
        mag  = $urandom_range(0, 12000);
        lim  = 16384 + mag - 512;
        c.a2 = COEF_W'(-mag);
        c.a1 = COEF_W'(int'($urandom_range(0, 2 * lim)) - lim);
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = S_MAX;
      1:       s = S_MIN;
      2:       s = '0;
      3, 4:    s = SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
      default: s = SAMPLE_W'($urandom());
    endcase
    return s;
  endfunction

  // receiving side: busy/quiet windows with random stall bursts, plus one
  // long hold-off on request so the pipe backs up into the input
  initial begin : rx_side
    int stall_pct;
    int window;
    int holds_done;
    stall_pct  = 0;
    window     = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (window <= 0) begin
        window = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      window--;
      if (rx_hold_ask != holds_done) begin
        holds_done = rx_hold_ask;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    coef_set_t c;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.sample_in <= '0;
    calm            <= 1'b0;
    rx_hold_ask     <= 0;
    gap_pct          = 20;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset coefficients: b0 at unity, so each output is the sample shifted up
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample('0);
    send_sample(16'sd1);
    send_sample(-16'sd1);

    // every coefficient most negative: most negative times most negative
    // saturates in the doubling and again in the q14 shift
    settle();
    c = '{b0: C_MIN, b1: C_MIN, b2: C_MIN, a1: C_MIN, a2: C_MIN};
    load_coefs(c);
    send_sample(S_MIN);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample('0);

    // every coefficient at its top: the sum saturates and the fed-back
    // output rounds into the q15 ceiling
    settle();
    c = '{b0: C_MAX, b1: C_MAX, b2: C_MAX, a1: C_MAX, a2: C_MAX};
    load_coefs(c);
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MIN);
    send_sample(S_MAX);

    // strong positive feedback against a negative second tap
    settle();
    c = '{b0: C_ONE, b1: '0, b2: '0, a1: C_MAX, a2: -C_ONE};
    load_coefs(c);
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MIN);

    // tiny b0: the first two outputs land exactly on the half-lsb rounding tie
    settle();
    c = '{b0: 16'sd1, b1: '0, b2: '0, a1: '0, a2: '0};
    load_coefs(c);
    send_sample(16'sh2000);
    send_sample(16'shE000);
    send_sample(-16'sd1);

    // random part: a fresh coefficient set per phase, one long receiver
    // hold-off, one full pause on the sending side, quiet last phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      c = pick_coefs();
      load_coefs(c);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 35;
      endcase
      if (ph == RAND_PHASES - 1) begin
        calm   <= 1'b1;
        gap_pct = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == HOLD_PHASE && n == PHASE_ITEMS / 4) begin
          rx_hold_ask <= rx_hold_ask + 1;
        end
        if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
          settle();
        end
        send_sample(pick_sample());
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("[biquad_iir_q14_saturating] OK");
    end else begin
      $display("[biquad_iir_q14_saturating] ERROR");
    end
    $finish;
  end

endmodule
